// File: rtl/core/fpr_pkg.sv
// fan pwm ramp sequencer: shared widths, register codes, reset values and types
`default_nettype none

package fpr_pkg;

  // field widths
  localparam int DUTY_W      = 8;
  localparam int TICK_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int SEC_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // duty value that maps to a full pwm period
  localparam int DUTY_FULL_SCALE = 200;

  // period * duty product, and the reciprocal used to divide it by full scale
  // (exact floor for every product of a 16-bit period and an 8-bit duty)
  localparam int PRODUCT_W = COUNT_W + DUTY_W;
  localparam int RECIP_K   = 32;
  localparam longint unsigned RECIP =
      ((64'd1 << RECIP_K) + DUTY_FULL_SCALE - 1) / DUTY_FULL_SCALE;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int QPROD_W   = PRODUCT_W + RECIP_W;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_OFF_DELAY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD      = 3'd4;

  // configuration reset values
  localparam logic [DUTY_W-1:0]  RST_RAMP_STEP       = 8'd3;
  localparam logic [DUTY_W-1:0]  RST_OFF_THRESHOLD   = 8'd30;
  localparam logic [TICK_W-1:0]  RST_START_DELAY     = 8'd5;
  localparam logic [TICK_W-1:0]  RST_POWER_OFF_DELAY = 8'd50;
  localparam logic [COUNT_W-1:0] RST_PWM_PERIOD      = 16'd1000;

  typedef struct packed {
    logic [DUTY_W-1:0]  ramp_step;
    logic [DUTY_W-1:0]  off_threshold;
    logic [TICK_W-1:0]  start_delay_ticks;
    logic [TICK_W-1:0]  power_off_delay_ticks;
    logic [COUNT_W-1:0] pwm_period;
  } cfg_t;

  // item in flight between the sequencer and the compare stage
  typedef struct packed {
    logic                 do_cmp;
    logic [PRODUCT_W-1:0] product;
    logic [COUNT_W-1:0]   period;
    logic                 supply_on;
    logic                 spin_cw;
    logic [DUTY_W-1:0]    ramp;
    logic [SEC_W-1:0]     run;
    logic [SEC_W-1:0]     stop;
  } stage_t;

endpackage

`default_nettype wire

// File: rtl/core/fpr_cfg.sv
// configuration register file for the fan pwm ramp sequencer
`default_nettype none

module fpr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fpr_pkg::cfg_t                       cfg
);
  import fpr_pkg::*;

  // writes are always accepted and registered
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step             <= RST_RAMP_STEP;
      cfg.off_threshold         <= RST_OFF_THRESHOLD;
      cfg.start_delay_ticks     <= RST_START_DELAY;
      cfg.power_off_delay_ticks <= RST_POWER_OFF_DELAY;
      cfg.pwm_period            <= RST_PWM_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAMP_STEP:       cfg.ramp_step             <= cfg_data[DUTY_W-1:0];
        REG_OFF_THRESHOLD:   cfg.off_threshold         <= cfg_data[DUTY_W-1:0];
        REG_START_DELAY:     cfg.start_delay_ticks     <= cfg_data[TICK_W-1:0];
        REG_POWER_OFF_DELAY: cfg.power_off_delay_ticks <= cfg_data[TICK_W-1:0];
        REG_PWM_PERIOD:      cfg.pwm_period            <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpr_seq.sv
// sequencer state: second counters, power sequencing, duty slew and period product
`default_nettype none

module fpr_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [fpr_pkg::DUTY_W-1:0] target_duty,
  input  wire logic                      tick_second,
  input  wire logic                      tick_tenth,
  input  wire fpr_pkg::cfg_t             cfg,
  output fpr_pkg::stage_t                stage
);
  import fpr_pkg::*;

  logic [DUTY_W-1:0] ramp;
  logic [DUTY_W-1:0] ramp_next;
  logic [TICK_W-1:0] powered;
  logic [TICK_W-1:0] powered_next;
  logic [TICK_W-1:0] idle;
  logic [TICK_W-1:0] idle_next;
  logic [SEC_W-1:0]  run;
  logic [SEC_W-1:0]  run_next;
  logic [SEC_W-1:0]  stop;
  logic [SEC_W-1:0]  stop_next;
  logic              supply_on;
  logic              supply_on_next;
  logic              spin_cw;
  logic              spin_cw_next;
  logic              do_cmp;
  logic [DUTY_W-1:0] ramp_slew;
  logic [DUTY_W:0]   up_sum;
  logic [DUTY_W:0]   down_sum;
  logic [PRODUCT_W-1:0] product;

  // slew toward the target, snapping to zero at or below threshold when the target is zero
  always_comb begin
    up_sum   = {1'b0, ramp} + {1'b0, cfg.ramp_step};
    down_sum = {1'b0, target_duty} + {1'b0, cfg.ramp_step};
    if (ramp <= cfg.off_threshold && target_duty == '0) begin
      ramp_slew = '0;
    end else if (ramp < target_duty) begin
      ramp_slew = (up_sum >= {1'b0, target_duty}) ? target_duty : up_sum[DUTY_W-1:0];
    end else if (ramp > target_duty) begin
      ramp_slew = ({1'b0, ramp} <= down_sum) ? target_duty : ramp - cfg.ramp_step;
    end else begin
      ramp_slew = ramp;
    end
  end

  // second counters, power step and ramp gating
  always_comb begin
    run_next       = run;
    stop_next      = stop;
    powered_next   = powered;
    idle_next      = idle;
    supply_on_next = supply_on;
    spin_cw_next   = spin_cw;
    ramp_next      = ramp;
    do_cmp         = 1'b0;
    if (tick_second) begin
      if (ramp != '0) begin
        if (run != '1) run_next = run + 1'b1;
        stop_next = '0;
      end else begin
        if (stop != '1) stop_next = stop + 1'b1;
        run_next = '0;
      end
    end
    if (tick_tenth) begin
      if (ramp != '0 || target_duty != '0) begin
        supply_on_next = 1'b1;
        spin_cw_next   = 1'b1;
        idle_next      = '0;
        if (powered != '1) powered_next = powered + 1'b1;
      end else begin
        powered_next = '0;
        if (idle != '1) begin
          idle_next = idle + 1'b1;
          if (idle_next == cfg.power_off_delay_ticks) begin
            supply_on_next = 1'b0;
            spin_cw_next   = 1'b0;
          end
        end
      end
      if (powered_next >= cfg.start_delay_ticks) begin
        do_cmp    = 1'b1;
        ramp_next = ramp_slew;
      end
    end
  end

  // period times duty, divided by full scale in the next stage
  assign product = {{DUTY_W{1'b0}}, cfg.pwm_period} * {{COUNT_W{1'b0}}, ramp_next};

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp      <= '0;
      powered   <= '0;
      idle      <= '0;
      run       <= '0;
      stop      <= '0;
      supply_on <= 1'b0;
      spin_cw   <= 1'b0;
    end else if (accept) begin
      ramp      <= ramp_next;
      powered   <= powered_next;
      idle      <= idle_next;
      run       <= run_next;
      stop      <= stop_next;
      supply_on <= supply_on_next;
      spin_cw   <= spin_cw_next;
    end
  end

  // item register toward the compare stage
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.do_cmp    <= do_cmp;
      stage.product   <= product;
      stage.period    <= cfg.pwm_period;
      stage.supply_on <= supply_on_next;
      stage.spin_cw   <= spin_cw_next;
      stage.ramp      <= ramp_next;
      stage.run       <= run_next;
      stage.stop      <= stop_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpr_cmp.sv
// compare stage: scales the product to a clamped compare count and holds the pin mode
`default_nettype none

module fpr_cmp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire fpr_pkg::stage_t             stage,
  output logic [fpr_pkg::COUNT_W-1:0]      duty_count,
  output logic                             pwm_pin_active,
  output logic                             motor_power,
  output logic                             direction_cw,
  output logic [fpr_pkg::DUTY_W-1:0]       ramped_duty,
  output logic [fpr_pkg::SEC_W-1:0]        run_seconds,
  output logic [fpr_pkg::SEC_W-1:0]        stop_seconds
);
  import fpr_pkg::*;

  logic [QPROD_W-1:0]   qprod;
  logic [PRODUCT_W-1:0] quotient;
  logic [COUNT_W-1:0]   count_clamped;

  // divide by full scale through the reciprocal, then clamp to the period
  assign qprod    = {{RECIP_W{1'b0}}, stage.product} * QPROD_W'(RECIP);
  assign quotient = PRODUCT_W'(qprod[QPROD_W-1:RECIP_K]);
  assign count_clamped = (quotient > {{DUTY_W{1'b0}}, stage.period}) ?
                         stage.period : quotient[COUNT_W-1:0];

  // compare count and pin mode only change when the ramp ran
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_count     <= '0;
      pwm_pin_active <= 1'b0;
    end else if (load && stage.do_cmp) begin
      duty_count     <= count_clamped;
      pwm_pin_active <= (count_clamped != '0);
    end
  end

  // remaining result fields
  always_ff @(posedge clk) begin
    if (load) begin
      motor_power  <= stage.supply_on;
      direction_cw <= stage.spin_cw;
      ramped_duty  <= stage.ramp;
      run_seconds  <= stage.run;
      stop_seconds <= stage.stop;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fan_pwm_ramp_power_sequencer_core.sv
// top level of the fan pwm ramp and motor power sequencer
//
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       target_duty, tick_second, tick_tenth
// out      output     out_valid / out_stall     duty_count .. stop_seconds
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; a taken item becomes a valid result
// through the sequencer register, then the reciprocal multiply into the result register
// synchronous reset restores all counters, the ramp and the register defaults
// out_stall holds the result register; the sequencer stage keeps taking items until
// it is full too, so in_stall follows out_stall only when both stages hold items
`default_nettype none

module fan_pwm_ramp_power_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fpr_pkg::DUTY_W-1:0]      target_duty,
  input  wire logic                            tick_second,
  input  wire logic                            tick_tenth,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fpr_pkg::COUNT_W-1:0]          duty_count,
  output logic                                 pwm_pin_active,
  output logic                                 motor_power,
  output logic                                 direction_cw,
  output logic [fpr_pkg::DUTY_W-1:0]           ramped_duty,
  output logic [fpr_pkg::SEC_W-1:0]            run_seconds,
  output logic [fpr_pkg::SEC_W-1:0]            stop_seconds,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpr_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid;
  logic   out_free;
  logic   stage_move;
  logic   accept;

  // pipeline handshake
  assign out_free   = !out_valid || !out_stall;
  assign stage_move = stage_valid && out_free;
  assign in_stall   = stage_valid && !out_free;
  assign accept     = in_valid && !in_stall;

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
      if (stage_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  fpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update per item
  fpr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .target_duty (target_duty),
    .tick_second (tick_second),
    .tick_tenth  (tick_tenth),
    .cfg         (cfg),
    .stage       (stage)
  );

  // compare count and result register
  fpr_cmp u_cmp (
    .clk            (clk),
    .rst            (rst),
    .load           (stage_move),
    .stage          (stage),
    .duty_count     (duty_count),
    .pwm_pin_active (pwm_pin_active),
    .motor_power    (motor_power),
    .direction_cw   (direction_cw),
    .ramped_duty    (ramped_duty),
    .run_seconds    (run_seconds),
    .stop_seconds   (stop_seconds)
  );

endmodule

`default_nettype wire
